FILE: hw/rtl/cbts_pkg.sv
// Shared constants, types and the timing word packing function for the
// CAN bit timing search block. No dependencies.
package cbts_pkg;

  localparam int ClkW  = 27;
  localparam int BaudW = 20;
  localparam int CpbW  = 27;
  localparam int DivW  = 4;
  localparam int QW    = 5;
  localparam int SegW  = 5;
  localparam int StepW = 10;
  localparam int ProdW = 14;
  localparam int TwW   = 15;

  localparam int DivCycles = CpbW;
  localparam int DivCntW   = $clog2(DivCycles);

  localparam logic [ClkW-1:0] ClkReset = ClkW'(48000000);
  localparam logic [DivW-1:0] DivMax   = 4'd15;
  localparam logic [QW-1:0]   QMaxM1   = 5'd31;
  localparam logic [SegW-1:0] SegsMin  = 5'd3;
  localparam logic [SegW-1:0] SegsMax  = 5'd17;

  typedef struct packed {
    logic done;
    logic found;
  } search_status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  // Packs quanta-1 and the segment count into the bit timing word.
  function automatic logic [TwW-1:0] pack_timing(input logic [QW-1:0] qm1,
                                                 input logic [SegW-1:0] segs);
    logic [SegW-1:0] extra;
    logic [3:0]      seg1;
    logic [3:0]      seg2;
    logic [1:0]      sjw;
    extra = segs - SegsMin;
    seg1  = extra[4:1];
    seg2  = extra[3:0] - seg1;
    sjw   = (seg1 > 4'd3) ? 2'd3 : seg1[1:0];
    return {seg2[2:0], seg1, sjw, 1'b0, qm1};
  endfunction

endpackage

FILE: hw/rtl/cbts_div.sv
// Restoring divider, one quotient bit per cycle: clocks per bit from the
// clock rate and the bit rate. Depends on cbts_pkg.
module cbts_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cbts_pkg::ClkW-1:0]  dividend,
  input  logic [cbts_pkg::BaudW-1:0] divisor,
  output logic                      done,
  output logic [cbts_pkg::CpbW-1:0]  quotient
);
  import cbts_pkg::*;

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [BaudW-1:0]   rem;
  logic [BaudW-1:0]   rem_next;
  logic [BaudW-1:0]   dvsr;
  logic [CpbW-1:0]    quo;
  logic [CpbW-1:0]    quo_next;
  logic [BaudW:0]     shifted;
  logic [BaudW:0]     diff;
  logic               ge;

  always_comb begin
    shifted  = {rem, quo[CpbW-1]};
    ge       = shifted >= {1'b0, dvsr};
    diff     = shifted - {1'b0, dvsr};
    rem_next = ge ? diff[BaudW-1:0] : shifted[BaudW-1:0];
    quo_next = {quo[CpbW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(DivCycles - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

FILE: hw/rtl/cbts_search.sv
// Search sequencer: walks divider, quanta and segment counts one candidate
// a cycle, with the product kept up to date by one shared adder.
// Depends on cbts_pkg.
module cbts_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cbts_pkg::CpbW-1:0]   cpb,
  output cbts_pkg::search_status_t   status,
  output logic [cbts_pkg::DivW-1:0]   clock_divider,
  output logic [cbts_pkg::TwW-1:0]    timing_word
);
  import cbts_pkg::*;

  logic             running;
  logic [CpbW-1:0]  cpb_r;
  logic [DivW-1:0]  div_cnt;
  logic [QW-1:0]    qm1;
  logic [SegW-1:0]  segs;
  logic [StepW-1:0] step;
  logic [ProdW-1:0] prod;
  logic [StepW-1:0] step_next;
  logic [ProdW-1:0] prod_next;
  logic [StepW-1:0] base;
  logic [ProdW-1:0] addend;
  logic             match;

  // step holds quanta * (divider + 1); prod holds segs * step. The single
  // adder either adds step for the next segment count or forms 3 * step
  // when the quanta or divider counter moves on.
  always_comb begin
    match     = {{(CpbW-ProdW){1'b0}}, prod} == cpb_r;
    step_next = step;
    base      = '0;
    if (segs != SegsMax) begin
      base = step;
    end else if (qm1 != QMaxM1) begin
      step_next = step + {{(StepW-DivW-1){1'b0}}, ({1'b0, div_cnt} + 5'd1)};
      base      = step_next;
    end else begin
      step_next = {{(StepW-DivW-1){1'b0}}, ({1'b0, div_cnt} + 5'd2)};
      base      = step_next;
    end
    addend = (segs != SegsMax) ? {{(ProdW-StepW){1'b0}}, base}
                               : {{(ProdW-StepW-1){1'b0}}, base, 1'b0};
    prod_next = ((segs != SegsMax) ? prod : {{(ProdW-StepW){1'b0}}, base}) + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      status  <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        running      <= 1'b1;
        status.found <= 1'b0;
      end else if (running) begin
        if (match) begin
          running      <= 1'b0;
          status.done  <= 1'b1;
          status.found <= 1'b1;
        end else if (segs == SegsMax && qm1 == QMaxM1 && div_cnt == DivMax) begin
          running     <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cpb_r         <= cpb;
      div_cnt       <= '0;
      qm1           <= '0;
      segs          <= SegsMin;
      step          <= StepW'(1);
      prod          <= ProdW'(3);
      clock_divider <= '0;
      timing_word   <= '0;
    end else if (running) begin
      if (match) begin
        clock_divider <= div_cnt;
        timing_word   <= pack_timing(qm1, segs);
      end else begin
        step <= step_next;
        prod <= prod_next;
        if (segs != SegsMax) begin
          segs <= segs + 1'b1;
        end else begin
          segs <= SegsMin;
          if (qm1 != QMaxM1) begin
            qm1 <= qm1 + 1'b1;
          end else begin
            qm1     <= '0;
            div_cnt <= div_cnt + 1'b1;
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/can_bit_timing_search.sv
// Top level of the CAN bit timing search: clock rate register, control
// sequencer and output register. Depends on cbts_pkg, cbts_div, cbts_search.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   bit_rate
//  out      source     out_valid / out_stall found, clock_divider, timing_word
//  cfg      sink       cfg_we                cfg_wdata (clock_rate_hz)
//
// Each item runs the divider, one quotient bit per cycle, then the search, one
// candidate per cycle, up to 7680 candidates; a zero bit rate skips both and
// goes straight to the result. The search adder visits one candidate a cycle.
// in_stall stays high from the transfer until the result is in the output
// register. Reset loads the clock rate with 48000000 and clears control.
module can_bit_timing_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cbts_pkg::BaudW-1:0]  bit_rate,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic [cbts_pkg::DivW-1:0]   clock_divider,
  output logic [cbts_pkg::TwW-1:0]    timing_word,
  input  logic                       cfg_we,
  input  logic [cbts_pkg::ClkW-1:0]   cfg_wdata
);
  import cbts_pkg::*;

  state_t         state;
  state_t         state_next;
  logic [ClkW-1:0] clock_rate_hz;
  logic            in_xfer;
  logic            out_load;
  logic            div_start;
  logic            div_done;
  logic [CpbW-1:0] cpb;
  logic            srch_start;
  search_status_t  srch_status;
  logic [DivW-1:0] srch_div;
  logic [TwW-1:0]  srch_tw;
  logic            res_found;
  logic [DivW-1:0] res_div;
  logic [TwW-1:0]  res_tw;

  assign in_stall   = state != S_IDLE;
  assign in_xfer    = in_valid && !in_stall;
  assign div_start  = in_xfer && bit_rate != '0;
  assign srch_start = state == S_DIV && div_done;
  assign out_load   = state == S_DONE && (!out_valid || !out_stall);

  cbts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_rate_hz),
    .divisor  (bit_rate),
    .done     (div_done),
    .quotient (cpb)
  );

  cbts_search u_search (
    .clk           (clk),
    .rst           (rst),
    .start         (srch_start),
    .cpb           (cpb),
    .status        (srch_status),
    .clock_divider (srch_div),
    .timing_word   (srch_tw)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (bit_rate == '0) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (srch_status.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      clock_rate_hz <= ClkReset;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        clock_rate_hz <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_found <= 1'b0;
      res_div   <= '0;
      res_tw    <= '0;
    end else if (state == S_SEARCH && srch_status.done) begin
      res_found <= srch_status.found;
      res_div   <= srch_div;
      res_tw    <= srch_tw;
    end
    if (out_load) begin
      found         <= res_found;
      clock_divider <= res_div;
      timing_word   <= res_tw;
    end
  end

`ifndef NO_ASSERTIONS
  a_srch_done_state: assert property (@(posedge clk) disable iff (rst)
    srch_status.done |-> state == S_SEARCH)
    else $error("search finished outside the search state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divide finished outside the divide state");

  a_zero_baud: assert property (@(posedge clk) disable iff (rst)
    in_xfer && bit_rate == '0 |=> state == S_DONE && !res_found)
    else $error("zero bit rate did not go straight to a not-found result");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("result load did not present a transfer and return to idle");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for can_bit_timing_search: random handshake gaps on both
// channels, clock rate register changes between phases, and a built-in timing search predictor.
// Depends on cbts_pkg and the can_bit_timing_search RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbts_pkg::*;

  localparam int BaudMax   = 1000000;
  localparam int ClkMax    = 100000000;
  localparam int IdleLimit = 40000;

  typedef struct packed {
    logic            hit;
    logic [DivW-1:0] divider;
    logic [TwW-1:0]  timing;
  } bit_timing_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [BaudW-1:0] bit_rate;
  logic             out_valid;
  logic             out_stall;
  logic             found;
  logic [DivW-1:0]  clock_divider;
  logic [TwW-1:0]   timing_word;
  logic             cfg_we;
  logic [ClkW-1:0]  cfg_wdata;

  bit_timing_t      pending_timings[$];
  logic [ClkW-1:0]  clock_rate;
  int               errors        = 0;
  int               items_sent    = 0;
  int               results_seen  = 0;
  int               matches_seen  = 0;
  int               rate_settings = 0;
  int               idle_cycles   = 0;
  int               in_quiet      = 0;
  int               out_quiet     = 0;

  can_bit_timing_search dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .bit_rate      (bit_rate),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .clock_divider (clock_divider),
    .timing_word   (timing_word),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Divider outermost, then quanta, then segments; the first exact product wins.
  function automatic bit_timing_t search_bit_timing(input logic [ClkW-1:0] rate,
                                                    input logic [BaudW-1:0] baud);
    bit_timing_t r;
    int unsigned cpb;
    int unsigned extra;
    int unsigned seg1;
    int unsigned seg2;
    int unsigned sjw;
    r = '0;
    if (baud == 0) return r;
    cpb = rate / baud;
    for (int d = 0; d <= 15; d++) begin
      for (int q = 1; q <= 32; q++) begin
        for (int s = 3; s <= 17; s++) begin
          if (cpb == s * q * (d + 1)) begin
            extra = s - 3;
            seg1 = extra / 2;
            seg2 = extra - seg1;
            sjw = (seg1 > 3) ? 3 : seg1;
            r.hit = 1'b1;
            r.divider = d[DivW-1:0];
            r.timing = {seg2[2:0], seg1[3:0], sjw[1:0], 6'(q - 1)};
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(5, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_baud(input logic [BaudW-1:0] b);
    int gap;
    gap = pick_gap(in_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bit_rate <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_timings.push_back(search_bit_timing(clock_rate, b));
    items_sent++;
  endtask

  // Drops valid and waits until every outstanding result has been received.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_timings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_clock_rate(input logic [ClkW-1:0] rate);
    @(negedge clk);
    cfg_wdata <= rate;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    clock_rate = rate;
    rate_settings++;
  endtask

  task automatic test_reset_rate();
    send_baud(0);
    send_baud(BaudW'(BaudMax));
    send_baud(500000);
    send_baud(125000);
    send_baud(524287);
    send_baud(1);
    send_baud(999999);
  endtask

  // Tiny clock rates: a quotient of zero, the shortest and the longest segment counts.
  task automatic test_small_rates();
    settle();
    write_clock_rate(17);
    send_baud(1);
    send_baud(5);
    send_baud(6);
    send_baud(17);
    send_baud(BaudW'(BaudMax));
    settle();
    write_clock_rate(1);
    send_baud(1);
    send_baud(BaudW'(BaudMax));
  endtask

  // Quotients that need a nonzero divider, up to the largest one, then the largest clock rate.
  task automatic test_divider_span();
    settle();
    write_clock_rate(8704000);
    send_baud(1000);
    send_baud(8000);
    send_baud(2000);
    send_baud(1);
    settle();
    write_clock_rate(ClkW'(ClkMax));
    send_baud(BaudW'(BaudMax));
    send_baud(3);
  endtask

  task automatic test_random_rates();
    int unsigned rate;
    int unsigned cpb;
    int unsigned b;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       rate = 67108863;
        1:       rate = ClkMax;
        default: rate = $urandom_range(1, ClkMax);
      endcase
      settle();
      write_clock_rate(rate[ClkW-1:0]);
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          // Aim the quotient at a reachable product so most items end in a match.
          cpb = $urandom_range(3, 17) * $urandom_range(1, 32);
          cpb = cpb * (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                 : $urandom_range(1, 16));
          b = rate / cpb;
          if (b == 0 || b > BaudMax) b = $urandom_range(1, BaudMax);
        end else if ($urandom_range(0, 9) == 0) begin
          b = 0;
        end else begin
          b = $urandom_range(0, BaudMax);
        end
        send_baud(b[BaudW-1:0]);
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      int n;
      n = pick_gap(out_quiet);
      @(negedge clk);
      if (n == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    bit_timing_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_timings.size() == 0) begin
        $display("%0t: unexpected result transfer found=%0b divider=%0d timing=%h",
                 $time, found, clock_divider, timing_word);
        errors++;
      end else begin
        want = pending_timings.pop_front();
        results_seen++;
        if (want.hit) matches_seen++;
        if (found !== want.hit) begin
          $display("%0t: found expected %0b actual %0b", $time, want.hit, found);
          errors++;
        end
        if (clock_divider !== want.divider) begin
          $display("%0t: clock_divider expected %0d actual %0d",
                   $time, want.divider, clock_divider);
          errors++;
        end
        if (timing_word !== want.timing) begin
          $display("%0t: timing_word expected %h actual %h", $time, want.timing, timing_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("FAIL can_bit_timing_search");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    bit_rate = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    clock_rate = ClkReset;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_rate();
    test_small_rates();
    test_divider_span();
    test_random_rates();
    settle();
    repeat (40) @(posedge clk);
    $display("Run covered %0d bit rate transfers and %0d results, %0d of them with a match,",
             items_sent, results_seen, matches_seen);
    $display("over the reset clock rate and %0d written clock rate settings.", rate_settings);
    if (errors == 0) begin
      $display("PASS can_bit_timing_search");
    end else begin
      $display("FAIL can_bit_timing_search");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cbts_pkg.sv
hw/rtl/cbts_div.sv
hw/rtl/cbts_search.sv
hw/rtl/can_bit_timing_search.sv
tb/sv/tb.sv
